// ===== src/gpi_pkg.sv =====
// Shared types and constants of the particle pair interaction block.
// Depends on nothing; gpi_div, gpi_front, gpi_queue, gpi_back and the top module import it.
package gpi_pkg;

    localparam int WORD_W      = 32;
    localparam int FORCE_W     = 64;
    localparam int DIST_W      = 64;
    localparam int DMAG_W      = 65;
    localparam int QUOT_W      = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [WORD_W-1:0] GRAVITY_RESET = 32'd65536;

    typedef enum logic [1:0] {
        KIND_GRAVITY    = 2'd0,
        KIND_COLLISION  = 2'd1,
        KIND_COINCIDENT = 2'd2
    } kind_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] rel_x;
        logic signed [WORD_W-1:0] rel_y;
        logic signed [WORD_W-1:0] rel_z;
        logic        [WORD_W-1:0] radius_sum;
        logic        [WORD_W-1:0] mass_a;
        logic        [WORD_W-1:0] mass_b;
        logic signed [WORD_W-1:0] vel_a_x;
        logic signed [WORD_W-1:0] vel_a_y;
        logic signed [WORD_W-1:0] vel_a_z;
        logic signed [WORD_W-1:0] vel_b_x;
        logic signed [WORD_W-1:0] vel_b_y;
        logic signed [WORD_W-1:0] vel_b_z;
    } pair_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic signed [FORCE_W-1:0] force_z;
        logic signed [WORD_W-1:0]  dv_a_x;
        logic signed [WORD_W-1:0]  dv_a_y;
        logic signed [WORD_W-1:0]  dv_a_z;
        logic signed [WORD_W-1:0]  dv_b_x;
        logic signed [WORD_W-1:0]  dv_b_y;
        logic signed [WORD_W-1:0]  dv_b_z;
        kind_t                     contact_kind;
    } result_t;

    // classified pair as it waits between front end and back end
    typedef struct packed {
        kind_t                   kind;
        logic [2:0]              rel_neg;
        logic [2:0][WORD_W-1:0]  rel_mag;
        logic [DIST_W-1:0]       dist_sq;
        logic [DMAG_W-1:0]       dmag;
        logic [WORD_W-1:0]       mass_a;
        logic [WORD_W-1:0]       mass_b;
    } work_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] rel_neg;
        logic       mass_zero;
    } ctrl_t;

endpackage

// ===== src/gpi_delay.sv =====
// Fixed-length register delay line.
// Depends on nothing.
module gpi_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else
        begin
            line_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[N-1];

endmodule

// ===== src/gpi_mul.sv =====
// Pipelined multiplier: one 32-bit limb of a times b per stage.
// Depends on nothing.
module gpi_mul #(
    parameter int AW = 64,
    parameter int BW = 32
) (
    input  logic             clk,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    localparam int LW = 32;
    localparam int L  = (AW + LW - 1) / LW;
    localparam int XW = L * LW;
    localparam int PW = AW + BW;
    localparam int MW = LW + BW;

    logic [XW-1:0] a_reg   [L];
    logic [BW-1:0] b_reg   [L];
    logic [PW-1:0] acc_reg [L];

    for (genvar k = 0; k < L; k++)
    begin : g_stage
        logic [XW-1:0]    a_in;
        logic [BW-1:0]    b_in;
        logic [PW-1:0]    acc_in;
        logic [LW+BW-1:0] part;

        if (k == 0)
        begin : g_first
            assign a_in   = XW'(a);
            assign b_in   = b;
            assign acc_in = '0;
        end
        else
        begin : g_next
            assign a_in   = a_reg[k-1];
            assign b_in   = b_reg[k-1];
            assign acc_in = acc_reg[k-1];
        end

        assign part = MW'(a_in[k*LW +: LW]) * MW'(b_in);

        always_ff @(posedge clk)
        begin
            a_reg[k]   <= a_in;
            b_reg[k]   <= b_in;
            acc_reg[k] <= acc_in + (PW'(part) << (k * LW));
        end
    end

    assign p = acc_reg[L-1];

endmodule

// ===== src/gpi_sqrt.sv =====
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// Depends on nothing.
module gpi_sqrt (
    input  logic        clk,
    input  logic [63:0] s,
    output logic [31:0] r
);

    localparam int SW = 64;
    localparam int RW = 32;

    logic [RW+1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [SW-1:0] src_reg  [RW];

    for (genvar j = 0; j < RW; j++)
    begin : g_stage
        logic [RW+1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [SW-1:0] src_in;
        logic [RW+3:0] cur;
        logic [RW+3:0] trial;
        logic [RW+3:0] diff;
        logic          ge;

        if (j == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign src_in  = s;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign src_in  = src_reg[j-1];
        end

        assign cur   = {rem_in, src_in[SW-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = cur >= trial;
        assign diff  = cur - trial;

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= ge ? diff[RW+1:0] : cur[RW+1:0];
            root_reg[j] <= {root_in[RW-2:0], ge};
            src_reg[j]  <= {src_in[SW-3:0], 2'b00};
        end
    end

    assign r = root_reg[RW-1];

endmodule

// ===== src/gpi_div.sv =====
// Pipelined restoring divider giving a 64-bit quotient and an overflow flag.
// Depends on gpi_pkg; one setup stage, then one stage per quotient bit.
module gpi_div
    import gpi_pkg::*;
#(
    parameter int NW = 128,
    parameter int DW = 96
) (
    input  logic              clk,
    input  logic [NW-1:0]     num,
    input  logic [DW-1:0]     den,
    output logic [QUOT_W-1:0] quot,
    output logic              over
);

    localparam int QW = QUOT_W;
    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [CW-1:0] hi_ext;
    logic [CW-1:0] den_ext;

    logic [DW-1:0] rem0_reg;
    logic [QW-1:0] lo0_reg;
    logic [DW-1:0] den0_reg;
    logic          over0_reg;

    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] quot_reg [QW];
    logic [QW-1:0] lo_reg   [QW];
    logic [DW-1:0] den_reg  [QW];
    logic          over_reg [QW];

    assign hi_ext  = CW'(num[NW-1:QW]);
    assign den_ext = CW'(den);

    always_ff @(posedge clk)
    begin
        rem0_reg  <= hi_ext[DW-1:0];
        lo0_reg   <= num[QW-1:0];
        den0_reg  <= den;
        over0_reg <= hi_ext >= den_ext;
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] quot_in;
        logic [QW-1:0] lo_in;
        logic [DW-1:0] den_in;
        logic          over_in;
        logic [DW:0]   cur;
        logic [DW:0]   diff;
        logic          ge;

        if (j == 0)
        begin : g_first
            assign rem_in  = rem0_reg;
            assign quot_in = '0;
            assign lo_in   = lo0_reg;
            assign den_in  = den0_reg;
            assign over_in = over0_reg;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign quot_in = quot_reg[j-1];
            assign lo_in   = lo_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign over_in = over_reg[j-1];
        end

        assign cur  = {rem_in, lo_in[QW-1]};
        assign ge   = cur >= {1'b0, den_in};
        assign diff = cur - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= ge ? diff[DW-1:0] : cur[DW-1:0];
            quot_reg[j] <= {quot_in[QW-2:0], ge};
            lo_reg[j]   <= {lo_in[QW-2:0], 1'b0};
            den_reg[j]  <= den_in;
            over_reg[j] <= over_in;
        end
    end

    assign quot = quot_reg[QW-1];
    assign over = over_reg[QW-1];

endmodule

// ===== src/gpi_front.sv =====
// Front end: takes pair beats, squares and dot products, classifies the pair.
// Depends on gpi_pkg; tracks queue credits to drive busy.
module gpi_front
    import gpi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  pair_t pair,
    input  logic  pop,
    output logic  busy,
    output logic  push_valid,
    output work_t push_item
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    logic             accept;
    logic [OCC_W-1:0] occ_reg, occ_next;

    logic [2:0][WORD_W-1:0] rel_raw, va_raw, vb_raw;

    logic                   v1_reg;
    logic [2:0]             rn1_reg, rn1_next;
    logic [2:0][WORD_W-1:0] rm1_reg, rm1_next;
    logic [2:0][DIST_W-1:0] sq1_reg, sq1_next;
    logic [2:0][DIST_W-1:0] pa1_reg, pa1_next;
    logic [2:0][DIST_W-1:0] pb1_reg, pb1_next;
    logic [2:0]             xa1_reg, xa1_next;
    logic [2:0]             xb1_reg, xb1_next;
    logic [DIST_W-1:0]      rssq1_reg, rssq1_next;
    logic [WORD_W-1:0]      ma1_reg, mb1_reg;

    logic  push_valid_reg;
    work_t push_item_reg, push_item_next;

    assign busy     = occ_reg == OCC_W'(QUEUE_DEPTH);
    assign accept   = start && !busy;
    assign occ_next = occ_reg + OCC_W'(accept) - OCC_W'(pop);

    assign rel_raw = {pair.rel_z, pair.rel_y, pair.rel_x};
    assign va_raw  = {pair.vel_a_z, pair.vel_a_y, pair.vel_a_x};
    assign vb_raw  = {pair.vel_b_z, pair.vel_b_y, pair.vel_b_x};

    always_comb
    begin
        logic [WORD_W-1:0] vam;
        logic [WORD_W-1:0] vbm;
        for (int i = 0; i < 3; i++)
        begin
            rn1_next[i] = rel_raw[i][WORD_W-1];
            rm1_next[i] = rn1_next[i] ? (~rel_raw[i] + 32'd1) : rel_raw[i];
            vam         = va_raw[i][WORD_W-1] ? (~va_raw[i] + 32'd1) : va_raw[i];
            vbm         = vb_raw[i][WORD_W-1] ? (~vb_raw[i] + 32'd1) : vb_raw[i];
            sq1_next[i] = DIST_W'(rm1_next[i]) * DIST_W'(rm1_next[i]);
            pa1_next[i] = DIST_W'(rm1_next[i]) * DIST_W'(vam);
            pb1_next[i] = DIST_W'(rm1_next[i]) * DIST_W'(vbm);
            xa1_next[i] = rn1_next[i] ^ va_raw[i][WORD_W-1];
            xb1_next[i] = rn1_next[i] ^ vb_raw[i][WORD_W-1];
        end
        rssq1_next = DIST_W'(pair.radius_sum) * DIST_W'(pair.radius_sum);
    end

    always_comb
    begin
        logic [DIST_W-1:0] s;
        logic [DIST_W-1:0] pos_a, neg_a, pos_b, neg_b;
        logic [DIST_W-1:0] la, lb;
        s     = sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
        pos_a = '0;
        neg_a = '0;
        pos_b = '0;
        neg_b = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (xa1_reg[i])
            begin
                neg_a = neg_a + pa1_reg[i];
            end
            else
            begin
                pos_a = pos_a + pa1_reg[i];
            end
            if (xb1_reg[i])
            begin
                neg_b = neg_b + pb1_reg[i];
            end
            else
            begin
                pos_b = pos_b + pb1_reg[i];
            end
        end
        la = (neg_a > pos_a) ? (neg_a - pos_a) : '0;
        lb = (pos_b > neg_b) ? (pos_b - neg_b) : '0;

        push_item_next.rel_neg = rn1_reg;
        push_item_next.rel_mag = rm1_reg;
        push_item_next.dist_sq = s;
        push_item_next.dmag    = DMAG_W'(la) + DMAG_W'(lb);
        push_item_next.mass_a  = ma1_reg;
        push_item_next.mass_b  = mb1_reg;
        priority if (s == '0)
        begin
            push_item_next.kind = KIND_COINCIDENT;
        end
        else if (s <= rssq1_reg)
        begin
            push_item_next.kind = KIND_COLLISION;
        end
        else
        begin
            push_item_next.kind = KIND_GRAVITY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg        <= '0;
            v1_reg         <= 1'b0;
            push_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg        <= occ_next;
            v1_reg         <= accept;
            push_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rn1_reg       <= rn1_next;
        rm1_reg       <= rm1_next;
        sq1_reg       <= sq1_next;
        pa1_reg       <= pa1_next;
        pb1_reg       <= pb1_next;
        xa1_reg       <= xa1_next;
        xb1_reg       <= xb1_next;
        rssq1_reg     <= rssq1_next;
        ma1_reg       <= pair.mass_a;
        mb1_reg       <= pair.mass_b;
        push_item_reg <= push_item_next;
    end

    assign push_valid = push_valid_reg;
    assign push_item  = push_item_reg;

endmodule

// ===== src/gpi_queue.sv =====
// Short FIFO between front end and back end.
// Depends on gpi_pkg for the entry type and depth.
module gpi_queue
    import gpi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_item,
    input  logic  pop,
    output logic  head_valid,
    output work_t head_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_valid  = count_reg != '0;
    assign head_item   = mem_reg[rd_ptr_reg];
    assign wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
    assign count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/gpi_back.sv =====
// Back end: root, products, quotients and saturation of one classified pair a cycle.
// Depends on gpi_pkg, gpi_delay, gpi_mul, gpi_sqrt and gpi_div.
module gpi_back
    import gpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  work_t             item,
    input  logic [WORD_W-1:0] gravity_constant,
    output logic              done,
    output result_t           result
);

    localparam int ALIGN     = WORD_W + 2;
    localparam int DIV_LAT   = QUOT_W + 1;
    localparam int TOTAL     = ALIGN + DIV_LAT;
    localparam int LAT_NUM_G = 6;
    localparam int LAT_DEN_C = 2;
    localparam int LAT_NUM_C = 7;

    localparam int K1W = 2 * WORD_W;
    localparam int KW  = 3 * WORD_W;
    localparam int NGW = KW + WORD_W;
    localparam int GNW = NGW + FRAC_BITS;
    localparam int DGW = DIST_W + WORD_W;
    localparam int MSW = WORD_W + 1;
    localparam int DCW = DIST_W + MSW;
    localparam int BSW = DMAG_W + WORD_W;
    localparam int B2W = BSW + 1;
    localparam int NCW = B2W + WORD_W;
    localparam int CTW = $bits(ctrl_t);

    logic [MSW-1:0]    msum;
    ctrl_t             ctrl_in, ctrl_d;
    logic              valid_d;

    logic [WORD_W-1:0] root;
    logic [DIST_W-1:0] s_d;
    logic [DGW-1:0]    den_g;
    logic [K1W-1:0]    k1;
    logic [KW-1:0]     kk;
    logic [WORD_W-1:0] mb_d1, mb_d3, ma_d3;
    logic [2:0][WORD_W-1:0] rm_d3;
    logic [DCW-1:0]    den_c, den_c_d;

    logic [QUOT_W-1:0] qg [3];
    logic              og [3];
    logic [QUOT_W-1:0] qa [3];
    logic              oa [3];
    logic [QUOT_W-1:0] qb [3];
    logic              ob [3];

    logic    done_reg;
    result_t result_reg, result_next;

    assign msum              = MSW'(item.mass_a) + MSW'(item.mass_b);
    assign ctrl_in.kind      = item.kind;
    assign ctrl_in.rel_neg   = item.rel_neg;
    assign ctrl_in.mass_zero = msum == '0;

    gpi_sqrt u_sqrt (.clk(clk), .s(item.dist_sq), .r(root));

    gpi_delay #(.W(DIST_W), .N(WORD_W)) u_dly_s
        (.clk(clk), .rst_n(rst_n), .d(item.dist_sq), .q(s_d));

    gpi_mul #(.AW(DIST_W), .BW(WORD_W)) u_mul_den_g
        (.clk(clk), .a(s_d), .b(root), .p(den_g));

    gpi_mul #(.AW(WORD_W), .BW(WORD_W)) u_mul_k1
        (.clk(clk), .a(gravity_constant), .b(item.mass_a), .p(k1));

    gpi_delay #(.W(WORD_W), .N(1)) u_dly_mb1
        (.clk(clk), .rst_n(rst_n), .d(item.mass_b), .q(mb_d1));

    gpi_mul #(.AW(K1W), .BW(WORD_W)) u_mul_k
        (.clk(clk), .a(k1), .b(mb_d1), .p(kk));

    gpi_delay #(.W(WORD_W), .N(2)) u_dly_mb3
        (.clk(clk), .rst_n(rst_n), .d(mb_d1), .q(mb_d3));

    gpi_delay #(.W(WORD_W), .N(3)) u_dly_ma3
        (.clk(clk), .rst_n(rst_n), .d(item.mass_a), .q(ma_d3));

    gpi_delay #(.W(3 * WORD_W), .N(3)) u_dly_rm
        (.clk(clk), .rst_n(rst_n), .d(item.rel_mag), .q(rm_d3));

    gpi_mul #(.AW(DIST_W), .BW(MSW)) u_mul_den_c
        (.clk(clk), .a(item.dist_sq), .b(msum), .p(den_c));

    gpi_delay #(.W(DCW), .N(ALIGN - LAT_DEN_C)) u_dly_den_c
        (.clk(clk), .rst_n(rst_n), .d(den_c), .q(den_c_d));

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        logic [NGW-1:0] ng, ng_d;
        logic [BSW-1:0] base;
        logic [NCW-1:0] na, na_d, nb, nb_d;

        gpi_mul #(.AW(KW), .BW(WORD_W)) u_mul_ng
            (.clk(clk), .a(kk), .b(rm_d3[i]), .p(ng));

        gpi_delay #(.W(NGW), .N(ALIGN - LAT_NUM_G)) u_dly_ng
            (.clk(clk), .rst_n(rst_n), .d(ng), .q(ng_d));

        gpi_mul #(.AW(DMAG_W), .BW(WORD_W)) u_mul_base
            (.clk(clk), .a(item.dmag), .b(item.rel_mag[i]), .p(base));

        gpi_mul #(.AW(B2W), .BW(WORD_W)) u_mul_na
            (.clk(clk), .a({base, 1'b0}), .b(mb_d3), .p(na));

        gpi_mul #(.AW(B2W), .BW(WORD_W)) u_mul_nb
            (.clk(clk), .a({base, 1'b0}), .b(ma_d3), .p(nb));

        gpi_delay #(.W(NCW), .N(ALIGN - LAT_NUM_C)) u_dly_na
            (.clk(clk), .rst_n(rst_n), .d(na), .q(na_d));

        gpi_delay #(.W(NCW), .N(ALIGN - LAT_NUM_C)) u_dly_nb
            (.clk(clk), .rst_n(rst_n), .d(nb), .q(nb_d));

        gpi_div #(.NW(GNW), .DW(DGW)) u_div_g
            (.clk(clk), .num({ng_d, {FRAC_BITS{1'b0}}}), .den(den_g),
             .quot(qg[i]), .over(og[i]));

        gpi_div #(.NW(NCW), .DW(DCW)) u_div_a
            (.clk(clk), .num(na_d), .den(den_c_d), .quot(qa[i]), .over(oa[i]));

        gpi_div #(.NW(NCW), .DW(DCW)) u_div_b
            (.clk(clk), .num(nb_d), .den(den_c_d), .quot(qb[i]), .over(ob[i]));
    end

    gpi_delay #(.W(CTW), .N(TOTAL)) u_dly_ctrl
        (.clk(clk), .rst_n(rst_n), .d(ctrl_in), .q(ctrl_d));

    gpi_delay #(.W(1), .N(TOTAL)) u_dly_valid
        (.clk(clk), .rst_n(rst_n), .d(item_valid), .q(valid_d));

    function automatic logic [FORCE_W-1:0] sat_force(
        input logic [QUOT_W-1:0] q,
        input logic              ovf,
        input logic              neg
    );
        logic [FORCE_W-1:0] lim;
        logic [FORCE_W-1:0] v;
        lim = neg ? {1'b1, {(FORCE_W-1){1'b0}}} : {1'b0, {(FORCE_W-1){1'b1}}};
        v   = (ovf || (FORCE_W'(q) > lim)) ? lim : FORCE_W'(q);
        return neg ? (~v + FORCE_W'(1)) : v;
    endfunction

    function automatic logic [WORD_W-1:0] sat_dv(
        input logic [QUOT_W-1:0] q,
        input logic              ovf,
        input logic              neg
    );
        logic [QUOT_W-1:0] lim;
        logic [WORD_W-1:0] v;
        lim = neg ? QUOT_W'({1'b1, {(WORD_W-1){1'b0}}})
                  : QUOT_W'({1'b0, {(WORD_W-1){1'b1}}});
        v   = (ovf || (q > lim)) ? lim[WORD_W-1:0] : q[WORD_W-1:0];
        return neg ? (~v + WORD_W'(1)) : v;
    endfunction

    always_comb
    begin
        result_next              = '0;
        result_next.contact_kind = ctrl_d.kind;
        unique case (ctrl_d.kind)
            KIND_GRAVITY:
            begin
                result_next.force_x = sat_force(qg[0], og[0], !ctrl_d.rel_neg[0]);
                result_next.force_y = sat_force(qg[1], og[1], !ctrl_d.rel_neg[1]);
                result_next.force_z = sat_force(qg[2], og[2], !ctrl_d.rel_neg[2]);
            end
            KIND_COLLISION:
            begin
                if (!ctrl_d.mass_zero)
                begin
                    result_next.dv_a_x = sat_dv(qa[0], oa[0], ctrl_d.rel_neg[0]);
                    result_next.dv_a_y = sat_dv(qa[1], oa[1], ctrl_d.rel_neg[1]);
                    result_next.dv_a_z = sat_dv(qa[2], oa[2], ctrl_d.rel_neg[2]);
                    result_next.dv_b_x = sat_dv(qb[0], ob[0], !ctrl_d.rel_neg[0]);
                    result_next.dv_b_y = sat_dv(qb[1], ob[1], !ctrl_d.rel_neg[1]);
                    result_next.dv_b_z = sat_dv(qb[2], ob[2], !ctrl_d.rel_neg[2]);
                end
            end
            KIND_COINCIDENT:
            begin
                result_next.contact_kind = KIND_COINCIDENT;
            end
            default:
            begin
                result_next.contact_kind = ctrl_d.kind;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_d;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/gravity_pair_interaction.sv =====
// Gravity force / elastic collision of one particle pair, Q16.16 in, saturated out.
// Path: done rises once the pair has passed the front end, the queue and the back end; the 64-step
// quotient pipeline and the 32-step square root pipeline make up most of that path.
// Throughput: one pair per cycle; busy rises only with four pairs held between ends.
// Reset: clears all control state and loads the gravitational constant with 1.0.
// Depends on gpi_pkg, gpi_front, gpi_queue and gpi_back.
module gravity_pair_interaction
    import gpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pair_t             pair,
    output logic              done,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WORD_W-1:0] cfg_data
);

    logic [WORD_W-1:0] gravity_reg, gravity_next;
    logic              push_valid;
    work_t             push_item;
    logic              head_valid;
    work_t             head_item;

    assign cfg_ready    = 1'b1;
    assign gravity_next = (cfg_valid && cfg_ready) ? cfg_data : gravity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= GRAVITY_RESET;
        end
        else
        begin
            gravity_reg <= gravity_next;
        end
    end

    gpi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .pair       (pair),
        .pop        (head_valid),
        .busy       (busy),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    gpi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_item  (push_item),
        .pop        (head_valid),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    gpi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (head_valid),
        .item             (head_item),
        .gravity_constant (gravity_reg),
        .done             (done),
        .result           (result)
    );

endmodule
